@@ hw/rtl/brcc_pkg.sv @@
`default_nettype none

package brcc_pkg;

   // fixed-point fraction bits of angle, gains and filter state
   localparam int FRAC_BITS = 8;

   // configuration port
   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   // register indexes
   localparam logic [2:0] REG_BALANCE_POINT  = 3'd0;
   localparam logic [2:0] REG_BALANCE_KP     = 3'd1;
   localparam logic [2:0] REG_BALANCE_KD     = 3'd2;
   localparam logic [2:0] REG_SPEED_KP       = 3'd3;
   localparam logic [2:0] REG_SPEED_KI       = 3'd4;
   localparam logic [2:0] REG_INTEGRAL_LIMIT = 3'd5;
   localparam logic [2:0] REG_TILT_LIMIT     = 3'd6;
   localparam logic [2:0] REG_PWM_LIMIT      = 3'd7;

   // reset values
   localparam logic signed [16:0] RST_BALANCE_POINT  = 17'sd0;
   localparam logic [9:0]         RST_BALANCE_KP     = 10'd300;
   localparam logic [15:0]        RST_BALANCE_KD     = 16'd276;
   localparam logic [9:0]         RST_SPEED_KP       = 10'd160;
   localparam logic [9:0]         RST_SPEED_KI       = 10'd205;
   localparam logic [15:0]        RST_INTEGRAL_LIMIT = 16'd10000;
   localparam logic [15:0]        RST_TILT_LIMIT     = 16'd10240;
   localparam logic [13:0]        RST_PWM_LIMIT      = 14'd6900;

   // datapath widths
   localparam int FE_W   = 26;              // filtered speed error
   localparam int SI_W   = 25;              // speed integral
   localparam int SIS_W  = SI_W + 2;        // integral plus error before clamp
   localparam int NUM_W  = 28;              // 4*fe - (left+right)*2^F
   localparam int MAG_W  = NUM_W - 1;
   localparam int MUL_W  = 29;              // shared multiplier operand
   localparam int PROD_W = 2 * MUL_W;
   localparam int ACC_W  = 48;
   localparam int BAL_W  = 28;
   localparam int VEL_W  = 30;
   localparam int CMD_W  = 32;

   // x/5 == (x * RECIP5) >> RECIP_SHIFT, exact for x < 2^MAG_W
   localparam int                 RECIP_SHIFT = 30;
   localparam logic [MUL_W-1:0]   RECIP5      = MUL_W'(((64'd1 << RECIP_SHIFT) + 64'd1) / 5);

endpackage

`default_nettype wire

@@ hw/rtl/balance_robot_cascade_controller_core.sv @@
// A skipped tick is taken while idle and gives no result; a control tick steps the sequencer
// through BAL_P, BAL_D, BAL_S, DIV, INT, VEL_P, VEL_I, VEL, SUM and OUT around the one shared
// 29x29 multiplier (five products, divide by 5 via reciprocal), taking no new item until OUT.
// Throughput: one item per cycle on skipped ticks; OUT waits for a free output register.
// The result sits in an output register, so the next item is accepted while it waits.
// Synchronous active-high reset zeroes sequencer, phase, stop and filter state, loads defaults.
`default_nettype none

module balance_robot_cascade_controller_core import brcc_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   // sensor tick in
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic signed [16:0]  req_tilt_angle,
   input  wire logic signed [16:0]  req_gyro_rate,
   input  wire logic signed [15:0]  req_left_count,
   input  wire logic signed [15:0]  req_right_count,
   input  wire logic                req_key_click,
   // motor command out
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [13:0]              rsp_motor_duty,
   output logic                     rsp_motor_forward,
   output logic                     rsp_drive_enabled,
   output logic                     rsp_stopped,
   // register port
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [ADDR_W-1:0]   paddr,
   input  wire logic [DATA_W-1:0]   pwdata,
   output logic [DATA_W-1:0]        prdata,
   output logic                     pready
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_BAL_P = 4'd1;
   localparam logic [3:0] ST_BAL_D = 4'd2;
   localparam logic [3:0] ST_BAL_S = 4'd3;
   localparam logic [3:0] ST_DIV   = 4'd4;
   localparam logic [3:0] ST_INT   = 4'd5;
   localparam logic [3:0] ST_VEL_P = 4'd6;
   localparam logic [3:0] ST_VEL_I = 4'd7;
   localparam logic [3:0] ST_VEL   = 4'd8;
   localparam logic [3:0] ST_SUM   = 4'd9;
   localparam logic [3:0] ST_OUT   = 4'd10;

   localparam logic signed [ACC_W-1:0] BIAS_F   = ACC_W'((64'sd1 <<< FRAC_BITS) - 64'sd1);
   localparam logic signed [ACC_W-1:0] BIAS_2F  = ACC_W'((64'sd1 <<< (2 * FRAC_BITS)) - 64'sd1);
   localparam logic signed [ACC_W-1:0] ZERO_ACC = ACC_W'(0);

   // configuration registers
   logic signed [16:0] bp_ff;
   logic [9:0]         kp_ff;
   logic [15:0]        kd_ff;
   logic [9:0]         skp_ff;
   logic [9:0]         ski_ff;
   logic [15:0]        il_ff;
   logic [15:0]        tl_ff;
   logic [13:0]        pwm_ff;

   // control and controller state
   logic [3:0]              state_ff;
   logic                    phase_ff;
   logic                    stop_ff;
   logic signed [FE_W-1:0]  fe_ff;
   logic signed [SI_W-1:0]  si_ff;
   logic [13:0]             held_ff;

   // latched item and datapath registers
   logic signed [16:0]      tilt_ff;
   logic signed [16:0]      gyro_ff;
   logic signed [15:0]      left_ff;
   logic signed [15:0]      right_ff;
   logic signed [NUM_W-1:0] num_ff;
   logic [MAG_W-1:0]        mag_ff;
   logic                    neg_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [BAL_W-1:0] bal_ff;
   logic signed [VEL_W-1:0] vel_ff;
   logic signed [CMD_W-1:0] cmd_ff;

   // output register
   logic        rsp_valid_ff;
   logic [13:0] duty_ff;
   logic        fwd_ff;
   logic        en_ff;
   logic        stopped_ff;

   logic                    accept;
   logic                    csr_write;
   logic signed [MUL_W-1:0] mul_a;
   logic signed [MUL_W-1:0] mul_b;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [17:0]      diff;
   logic signed [16:0]      sum_lr;
   logic signed [NUM_W-1:0] num_in;
   logic signed [ACC_W-1:0] acc_biased;
   logic signed [ACC_W-1:0] bal_w;
   logic signed [ACC_W-1:0] vel_w;
   logic [FE_W-1:0]         quot;
   logic signed [FE_W-1:0]  fe_in;
   logic signed [SIS_W-1:0] si_sum;
   logic signed [SIS_W-1:0] ilim;
   logic signed [SIS_W-1:0] si_cl;
   logic signed [CMD_W-1:0] plim;
   logic signed [CMD_W-1:0] cmd_cl;
   logic [CMD_W-1:0]        cmd_abs;
   logic [16:0]             tilt_abs;
   logic                    drive_off;
   logic                    out_free;

   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign accept    = req_valid && req_ready;
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_motor_duty    = duty_ff;
   assign rsp_motor_forward = fwd_ff;
   assign rsp_drive_enabled = en_ff;
   assign rsp_stopped       = stopped_ff;

   // register read
   always_comb begin
      unique case (paddr[4:2])
         REG_BALANCE_POINT:  prdata = DATA_W'(bp_ff);
         REG_BALANCE_KP:     prdata = DATA_W'(kp_ff);
         REG_BALANCE_KD:     prdata = DATA_W'(kd_ff);
         REG_SPEED_KP:       prdata = DATA_W'(skp_ff);
         REG_SPEED_KI:       prdata = DATA_W'(ski_ff);
         REG_INTEGRAL_LIMIT: prdata = DATA_W'(il_ff);
         REG_TILT_LIMIT:     prdata = DATA_W'(tl_ff);
         REG_PWM_LIMIT:      prdata = DATA_W'(pwm_ff);
         default:            prdata = '0;
      endcase
   end

   // shared multiplier operand select
   assign diff = 18'(tilt_ff) - 18'(bp_ff);

   always_comb begin
      unique case (state_ff)
         ST_BAL_P: begin
            mul_a = MUL_W'(diff);
            mul_b = signed'(MUL_W'(kp_ff));
         end
         ST_BAL_D: begin
            mul_a = MUL_W'(gyro_ff);
            mul_b = signed'(MUL_W'(kd_ff));
         end
         ST_BAL_S: begin
            mul_a = signed'(MUL_W'(mag_ff));
            mul_b = signed'(RECIP5);
         end
         ST_INT: begin
            mul_a = MUL_W'(fe_ff);
            mul_b = signed'(MUL_W'(skp_ff));
         end
         ST_VEL_P: begin
            mul_a = MUL_W'(si_ff);
            mul_b = signed'(MUL_W'(ski_ff));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // 4*fe - (left+right)*2^F, its magnitude goes through the reciprocal multiply
   assign sum_lr = 17'(left_ff) + 17'(right_ff);
   assign num_in = (NUM_W'(fe_ff) <<< 2) - (NUM_W'(sum_lr) <<< FRAC_BITS);

   assign quot  = prod_ff[RECIP_SHIFT +: FE_W];
   assign fe_in = neg_ff ? -signed'(quot) : signed'(quot);

   // shifts that truncate toward zero
   assign acc_biased = acc_ff + (acc_ff[ACC_W-1] ?
                       ((state_ff == ST_DIV) ? BIAS_F : BIAS_2F) : ZERO_ACC);
   assign bal_w = acc_biased >>> FRAC_BITS;
   assign vel_w = acc_biased >>> (2 * FRAC_BITS);

   // integral clamp
   assign si_sum = SIS_W'(si_ff) + SIS_W'(fe_ff);
   assign ilim   = signed'(SIS_W'(il_ff) << FRAC_BITS);
   always_comb begin
      if (si_sum > ilim) begin
         si_cl = ilim;
      end else if (si_sum < -ilim) begin
         si_cl = -ilim;
      end else begin
         si_cl = si_sum;
      end
   end

   // command clamp and cut-off
   assign plim = signed'(CMD_W'(pwm_ff));
   always_comb begin
      if (cmd_ff > plim) begin
         cmd_cl = plim;
      end else if (cmd_ff < -plim) begin
         cmd_cl = -plim;
      end else begin
         cmd_cl = cmd_ff;
      end
   end
   assign cmd_abs   = cmd_cl[CMD_W-1] ? unsigned'(-cmd_cl) : unsigned'(cmd_cl);
   assign tilt_abs  = tilt_ff[16] ? unsigned'(-tilt_ff) : unsigned'(tilt_ff);
   assign drive_off = (tilt_abs > 17'(tl_ff)) || stop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bp_ff  <= RST_BALANCE_POINT;
         kp_ff  <= RST_BALANCE_KP;
         kd_ff  <= RST_BALANCE_KD;
         skp_ff <= RST_SPEED_KP;
         ski_ff <= RST_SPEED_KI;
         il_ff  <= RST_INTEGRAL_LIMIT;
         tl_ff  <= RST_TILT_LIMIT;
         pwm_ff <= RST_PWM_LIMIT;
      end else if (csr_write) begin
         unique case (paddr[4:2])
            REG_BALANCE_POINT:  bp_ff  <= signed'(pwdata[16:0]);
            REG_BALANCE_KP:     kp_ff  <= pwdata[9:0];
            REG_BALANCE_KD:     kd_ff  <= pwdata[15:0];
            REG_SPEED_KP:       skp_ff <= pwdata[9:0];
            REG_SPEED_KI:       ski_ff <= pwdata[9:0];
            REG_INTEGRAL_LIMIT: il_ff  <= pwdata[15:0];
            REG_TILT_LIMIT:     tl_ff  <= pwdata[15:0];
            REG_PWM_LIMIT:      pwm_ff <= pwdata[13:0];
            default:            ;
         endcase
      end
   end

   // sequencer and controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= 1'b0;
         stop_ff      <= 1'b0;
         fe_ff        <= '0;
         si_ff        <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a new result may replace the one taken at this edge
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  phase_ff <= ~phase_ff;
                  // only control ticks sample the click
                  if (phase_ff) begin
                     stop_ff  <= stop_ff ^ req_key_click;
                     state_ff <= ST_BAL_P;
                  end
               end
            end
            ST_BAL_P: state_ff <= ST_BAL_D;
            ST_BAL_D: state_ff <= ST_BAL_S;
            ST_BAL_S: state_ff <= ST_DIV;
            ST_DIV: begin
               fe_ff    <= fe_in;
               state_ff <= ST_INT;
            end
            ST_INT: begin
               si_ff    <= si_cl[SI_W-1:0];
               state_ff <= ST_VEL_P;
            end
            ST_VEL_P: state_ff <= ST_VEL_I;
            ST_VEL_I: state_ff <= ST_VEL;
            ST_VEL:   state_ff <= ST_SUM;
            ST_SUM:   state_ff <= ST_OUT;
            ST_OUT: begin
               if (out_free) begin
                  if (drive_off) begin
                     si_ff <= '0;
                  end else begin
                     held_ff <= cmd_abs[13:0];
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         tilt_ff  <= req_tilt_angle;
         gyro_ff  <= req_gyro_rate;
         left_ff  <= req_left_count;
         right_ff <= req_right_count;
      end
      prod_ff <= prod_in;
      case (state_ff)
         ST_BAL_P: num_ff <= num_in;
         ST_BAL_D: begin
            acc_ff <= ACC_W'(prod_ff);
            neg_ff <= num_ff[NUM_W-1];
            mag_ff <= num_ff[NUM_W-1] ? MAG_W'(-num_ff) : MAG_W'(num_ff);
         end
         ST_BAL_S: acc_ff <= acc_ff + ACC_W'(prod_ff);
         ST_DIV:   bal_ff <= bal_w[BAL_W-1:0];
         ST_VEL_P: acc_ff <= -(ACC_W'(prod_ff) <<< FRAC_BITS);
         ST_VEL_I: acc_ff <= acc_ff - ACC_W'(prod_ff);
         ST_VEL:   vel_ff <= vel_w[VEL_W-1:0];
         ST_SUM:   cmd_ff <= CMD_W'(bal_ff) + CMD_W'(vel_ff);
         ST_OUT: begin
            if (out_free) begin
               stopped_ff <= stop_ff;
               if (drive_off) begin
                  duty_ff <= held_ff;
                  fwd_ff  <= 1'b0;
                  en_ff   <= 1'b0;
               end else begin
                  duty_ff <= cmd_abs[13:0];
                  fwd_ff  <= (cmd_cl > 0);
                  en_ff   <= 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

`ifndef SYNTHESIS
   a_off_no_dir: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_drive_enabled |-> !rsp_motor_forward)
      else $error("direction set while drive is off");

   a_duty_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_drive_enabled |-> (rsp_motor_duty <= pwm_ff))
      else $error("duty above pwm limit");

   a_result_phase: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !phase_ff)
      else $error("result outside a control tick");

   a_ctrl_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && phase_ff |=> !req_ready)
      else $error("control tick did not start the sequencer");
`endif

endmodule

`default_nettype wire
